// ===== rtl/clcr_pkg.sv =====
// Shared types, constants and command-matching functions for the console line recognizer.
package clcr_pkg;

  localparam int unsigned LineBytes = 32;
  localparam int unsigned FillW     = $clog2(LineBytes);

  localparam logic [7:0] ChLf = 8'd10;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChBs = 8'd8;
  localparam logic [7:0] ChSp = 8'd32;
  localparam logic [7:0] ChQm = 8'd63;

  typedef enum logic [1:0] {
    CMD_ON      = 2'd0,
    CMD_OFF     = 2'd1,
    CMD_VOLT    = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  // Progress of the held text against the three command words.
  typedef enum logic [3:0] {
    CL_EMPTY,
    CL_O,
    CL_ON,
    CL_OF,
    CL_OFF,
    CL_V,
    CL_VO,
    CL_VOL,
    CL_VOLT,
    CL_VOLTQ,
    CL_OTHER
  } cls_e;

  // Match status of the text up to and including one held character.
  typedef struct packed {
    logic frozen;  // A zero byte has ended the matched text.
    cls_e cls;
  } status_t;

  typedef struct packed {
    status_t    st;
    logic [7:0] ch;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    cmd_e       command;
    logic       last;
  } result_t;

  localparam status_t StatusEmpty = '{frozen: 1'b0, cls: CL_EMPTY};

  function automatic cls_e cls_step(cls_e cls, logic [7:0] ch);
    cls_e nxt;
    nxt = CL_OTHER;
    case (cls)
      CL_EMPTY: begin
        if (ch == "o") nxt = CL_O;
        else if (ch == "v") nxt = CL_V;
      end
      CL_O: begin
        if (ch == "n") nxt = CL_ON;
        else if (ch == "f") nxt = CL_OF;
      end
      CL_OF:   if (ch == "f") nxt = CL_OFF;
      CL_V:    if (ch == "o") nxt = CL_VO;
      CL_VO:   if (ch == "l") nxt = CL_VOL;
      CL_VOL:  if (ch == "t") nxt = CL_VOLT;
      CL_VOLT: if (ch == "?") nxt = CL_VOLTQ;
      default: nxt = CL_OTHER;
    endcase
    return nxt;
  endfunction

  function automatic status_t status_step(status_t st, logic [7:0] ch);
    status_t nxt;
    nxt = st;
    if (st.frozen || ch == 8'd0) begin
      nxt.frozen = 1'b1;
    end else begin
      nxt.cls = cls_step(st.cls, ch);
    end
    return nxt;
  endfunction

  function automatic cmd_e status_to_cmd(status_t st);
    cmd_e cmd;
    case (st.cls)
      CL_ON:    cmd = CMD_ON;
      CL_OFF:   cmd = CMD_OFF;
      CL_VOLTQ: cmd = CMD_VOLT;
      default:  cmd = CMD_UNKNOWN;
    endcase
    return cmd;
  endfunction

endpackage

// ===== rtl/clcr_line_mem.sv =====
// Line buffer memory: one write port and one read port with registered read data.
module clcr_line_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [clcr_pkg::FillW-1:0] waddr_i,
  input  clcr_pkg::entry_t           wdata_i,
  input  logic                       re_i,
  input  logic [clcr_pkg::FillW-1:0] raddr_i,
  output clcr_pkg::entry_t           rdata_o
);

  clcr_pkg::entry_t mem_q [clcr_pkg::LineBytes];
  clcr_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/console_line_command_recognizer.sv =====
// Top level: console line editor that echoes bytes and reports recognized commands.
//
//   channel | direction | handshake               | payload
//   rx      | in        | rx_valid_i / rx_ready_o | rx_byte_i
//   res     | out       | res_valid_o / res_ready_i | kind_o, tx_byte_o, command_o, last_o
//
// An accepted byte yields zero to three words from a result buffer, one word per cycle
// while res_ready_i is high: a line feed or a backspace on an empty line yields none,
// a plain character one, and a CR or other backspace three.
// The next byte is taken in the cycle the last buffered word leaves.
// Each held character is stored with its command-match status; a backspace reads the
// previous entry back into the read register, and the read completes while its echo drains.
// Reset empties the line; buffer contents before reset are never read.
module console_line_command_recognizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       kind_o,
  output logic [7:0] tx_byte_o,
  output logic [1:0] command_o,
  output logic       last_o
);

  logic [clcr_pkg::FillW-1:0] fill_q, fill_d;
  clcr_pkg::status_t          tail_q, tail_d;
  logic                       tail_mem_q, tail_mem_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [1:0]                 idx_q, idx_d;
  clcr_pkg::result_t          res_q [3];
  clcr_pkg::result_t          res_d [3];
  clcr_pkg::result_t          res_cur;

  logic                       rx_fire;
  logic                       res_fire;
  clcr_pkg::status_t          tail_eff;
  clcr_pkg::status_t          st_new;

  logic                       mem_we;
  logic                       mem_re;
  logic [clcr_pkg::FillW-1:0] mem_waddr;
  logic [clcr_pkg::FillW-1:0] mem_raddr;
  clcr_pkg::entry_t           mem_wdata;
  clcr_pkg::entry_t           mem_rdata;

  clcr_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_valid_o = (cnt_q != 2'd0);
  assign res_fire    = res_valid_o && res_ready_i;
  assign rx_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && res_ready_i);
  assign rx_fire     = rx_valid_i && rx_ready_o;

  // After a backspace the status of the new last character sits in the read register.
  assign tail_eff = tail_mem_q ? mem_rdata.st : tail_q;
  assign st_new   = clcr_pkg::status_step(tail_eff, rx_byte_i);

  always_comb begin
    fill_d     = fill_q;
    tail_d     = tail_q;
    tail_mem_d = tail_mem_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = fill_q;
    mem_raddr  = fill_q - clcr_pkg::FillW'(2);
    mem_wdata  = '{st: st_new, ch: rx_byte_i};

    if (res_fire) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end

    if (rx_fire) begin
      idx_d = 2'd0;
      cnt_d = 2'd0;
      if (rx_byte_i == clcr_pkg::ChLf) begin
        cnt_d = 2'd0;
      end else if (rx_byte_i == clcr_pkg::ChCr) begin
        res_d[0]   = '{kind: 1'b0, tx_byte: clcr_pkg::ChCr,
                       command: clcr_pkg::CMD_ON, last: 1'b0};
        res_d[1]   = '{kind: 1'b0, tx_byte: clcr_pkg::ChLf,
                       command: clcr_pkg::CMD_ON, last: 1'b0};
        res_d[2]   = '{kind: 1'b1, tx_byte: 8'd0,
                       command: clcr_pkg::status_to_cmd(tail_eff), last: 1'b1};
        cnt_d      = 2'd3;
        fill_d     = '0;
        tail_d     = clcr_pkg::StatusEmpty;
        tail_mem_d = 1'b0;
      end else if (rx_byte_i == clcr_pkg::ChBs) begin
        if (fill_q != '0) begin
          res_d[0] = '{kind: 1'b0, tx_byte: clcr_pkg::ChBs,
                       command: clcr_pkg::CMD_ON, last: 1'b0};
          res_d[1] = '{kind: 1'b0, tx_byte: clcr_pkg::ChSp,
                       command: clcr_pkg::CMD_ON, last: 1'b0};
          res_d[2] = '{kind: 1'b0, tx_byte: clcr_pkg::ChBs,
                       command: clcr_pkg::CMD_ON, last: 1'b1};
          cnt_d    = 2'd3;
          fill_d   = fill_q - clcr_pkg::FillW'(1);
          if (fill_q == clcr_pkg::FillW'(1)) begin
            tail_d     = clcr_pkg::StatusEmpty;
            tail_mem_d = 1'b0;
          end else begin
            mem_re     = 1'b1;
            tail_mem_d = 1'b1;
          end
        end
      end else if (fill_q != clcr_pkg::FillW'(clcr_pkg::LineBytes - 1)) begin
        mem_we     = 1'b1;
        res_d[0]   = '{kind: 1'b0, tx_byte: rx_byte_i,
                       command: clcr_pkg::CMD_ON, last: 1'b1};
        cnt_d      = 2'd1;
        fill_d     = fill_q + clcr_pkg::FillW'(1);
        tail_d     = st_new;
        tail_mem_d = 1'b0;
      end else begin
        res_d[0] = '{kind: 1'b0, tx_byte: clcr_pkg::ChQm,
                     command: clcr_pkg::CMD_ON, last: 1'b1};
        cnt_d    = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      tail_q     <= clcr_pkg::StatusEmpty;
      tail_mem_q <= 1'b0;
      cnt_q      <= 2'd0;
      idx_q      <= 2'd0;
    end else begin
      fill_q     <= fill_d;
      tail_q     <= tail_d;
      tail_mem_q <= tail_mem_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    case (idx_q)
      2'd0:    res_cur = res_q[0];
      2'd1:    res_cur = res_q[1];
      default: res_cur = res_q[2];
    endcase
  end

  assign kind_o    = res_cur.kind;
  assign tx_byte_o = res_cur.tx_byte;
  assign command_o = res_cur.command;
  assign last_o    = res_cur.last;

endmodule
